// ----- rtl/cmwc_pkg.sv -----
// Shared types and constants of the complementary multiply-with-carry generator.
`default_nettype none

package cmwc_pkg;

   // Table depth used when the top level is not given another one.
   localparam int unsigned TABLE_DEPTH_DEFAULT = 4096;

   // Word widths.
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned MULT_W  = 15;
   localparam int unsigned CARRY_W = 19;
   localparam int unsigned T_W     = WORD_W + MULT_W + 1;

   // Arithmetic constants of the generator.
   localparam logic [WORD_W-1:0]  GOLDEN_STEP    = 32'h9e37_79b9;
   localparam logic [MULT_W-1:0]  MULTIPLIER     = 15'd18705;
   localparam logic [WORD_W-1:0]  CMWC_BASE      = 32'hffff_fffe;
   localparam logic [CARRY_W-1:0] CARRY_AT_RESET = 19'd362436;

   // Register map of the configuration port.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_SEED_VALUE = 1'b0;

   // Operation codes carried in the request tuser.
   typedef enum logic [1:0] {
      MODE_DRAW = 2'd0,
      MODE_SEED = 2'd1,
      MODE_LOAD = 2'd2
   } mode_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW,
      ST_FILL,
      ST_WARM_START,
      ST_WARM
   } state_type;

endpackage : cmwc_pkg

`default_nettype wire

// ----- rtl/cmwc_random_generator_unit.sv -----
// Top level of the complementary multiply-with-carry generator over a lag table memory.
// Draw word: memory read, then multiply-add and write back with the result. Load: a single table write.
// Seed word: a fill pass over the table, a start state and a pipelined warm-up pass.
// One word is taken at a time; a draw that finds a result still held waits before writing back.
// Reset clears the sequencer and the seed register and sets the carry (362436) and position
// (TABLE_DEPTH-1); the lag table is not cleared and holds nothing defined until written.
`default_nettype none

module cmwc_random_generator_unit #(
   parameter int unsigned TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   // Request words: tdata = entry_index[11:0], entry_value[43:12], zero pad [47:44].
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [47:0]                     req_tdata,
   // Request tuser = mode[1:0].
   input  wire logic [1:0]                      req_tuser,

   // Result words: tdata = random_word[31:0].
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [cmwc_pkg::WORD_W-1:0]          rsp_tdata,

   // Configuration port.
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [cmwc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   import cmwc_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam logic [AW-1:0] INDEX_LAST = AW'(TABLE_DEPTH - 1);

   // Lag table and its registered read data.
   logic [WORD_W-1:0] lag_table [TABLE_DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   // Control and payload registers.
   state_type          state_ff, state_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [CARRY_W-1:0] carry_ff, carry_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic [WORD_W-1:0]  hist_a_ff, hist_a_in;
   logic [WORD_W-1:0]  hist_b_ff, hist_b_in;
   logic [WORD_W-1:0]  hist_c_ff, hist_c_in;
   logic [WORD_W-1:0]  seed_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_data_ff, rsp_data_in;

   // Memory port controls.
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata;

   // Datapath.
   logic               req_fire;
   logic               calc_fire;
   mode_type           req_mode;
   logic [11:0]        req_index;
   logic [WORD_W-1:0]  req_value;
   logic [T_W-1:0]     calc_t;
   logic [WORD_W-1:0]  calc_word;
   logic [CARRY_W-1:0] calc_carry;
   logic [WORD_W-1:0]  fill_value;
   logic               csr_write;

   assign req_fire  = req_tvalid && req_tready;
   assign req_mode  = mode_type'(req_tuser);
   assign req_index = req_tdata[11:0];
   assign req_value = req_tdata[43:12];

   // Multiply-add of the fetched entry with the running carry.
   always_comb begin
      calc_t     = T_W'(rdata_ff) * T_W'(MULTIPLIER) + T_W'(carry_ff);
      calc_carry = CARRY_W'(calc_t >> WORD_W);
      calc_word  = CMWC_BASE - calc_t[WORD_W-1:0];
   end

   // Golden-ratio recurrence used while filling the table from the seed.
   always_comb begin
      priority if (cnt_ff == '0) begin
         fill_value = seed_ff;
      end else if (cnt_ff < AW'(3)) begin
         fill_value = hist_c_ff + GOLDEN_STEP;
      end else begin
         fill_value = hist_a_ff ^ hist_b_ff ^ GOLDEN_STEP ^ WORD_W'(cnt_ff);
      end
   end

   // Sequencer: next state, memory port and register updates.
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      carry_in   = carry_ff;
      cnt_in     = cnt_ff;
      hist_a_in  = hist_a_ff;
      hist_b_in  = hist_b_ff;
      hist_c_in  = hist_c_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_waddr  = pos_ff;
      mem_raddr  = pos_ff + AW'(1);
      mem_wdata  = calc_word;
      req_tready = 1'b0;
      calc_fire  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               unique case (req_mode)
                  MODE_DRAW: begin
                     mem_re   = 1'b1;
                     pos_in   = pos_ff + AW'(1);
                     state_in = ST_DRAW;
                  end
                  MODE_SEED: begin
                     cnt_in   = '0;
                     state_in = ST_FILL;
                  end
                  MODE_LOAD: begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(req_index);
                     mem_wdata = req_value;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DRAW: begin
            // Wait for room in the output register, then write back and emit.
            if (!rsp_valid_ff || rsp_tready) begin
               calc_fire = 1'b1;
               mem_we    = 1'b1;
               carry_in  = calc_carry;
               state_in  = ST_IDLE;
            end
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = fill_value;
            hist_a_in = hist_b_ff;
            hist_b_in = hist_c_ff;
            hist_c_in = fill_value;
            if (cnt_ff == INDEX_LAST) begin
               cnt_in   = '0;
               state_in = ST_WARM_START;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_WARM_START: begin
            mem_re   = 1'b1;
            pos_in   = pos_ff + AW'(1);
            state_in = ST_WARM;
         end
         ST_WARM: begin
            // Write back the current entry while fetching the next one.
            mem_we   = 1'b1;
            carry_in = calc_carry;
            if (cnt_ff == INDEX_LAST) begin
               state_in = ST_IDLE;
            end else begin
               mem_re = 1'b1;
               pos_in = pos_ff + AW'(1);
               cnt_in = cnt_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (calc_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = calc_word;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_SEED_VALUE) ? seed_ff : '0;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= INDEX_LAST;
         carry_ff     <= CARRY_AT_RESET;
         cnt_ff       <= '0;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         carry_ff     <= carry_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_paddr[2] == REG_SEED_VALUE) begin
            seed_ff <= csr_pwdata;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hist_a_ff   <= hist_a_in;
      hist_b_ff   <= hist_b_in;
      hist_c_ff   <= hist_c_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Lag table: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lag_table[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= lag_table[mem_raddr];
      end
   end

   // A result only appears after a draw has been written back.
   a_rsp_from_draw : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DRAW))
      else $error("result word raised outside a draw write back");

   // The pipelined warm-up never reads the entry it is writing.
   a_no_rw_clash : assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("lag table read and write at the same entry");

   // After any generator step the carry stays within the multiplier.
   a_carry_bound : assert property (@(posedge clock) disable iff (reset)
      (calc_fire || state_ff == ST_WARM) |=> (carry_ff <= CARRY_W'(MULTIPLIER)))
      else $error("carry exceeds the multiplier after a step");

endmodule : cmwc_random_generator_unit

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the CMWC random generator unit, driven over its stream and APB ports.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cmwc_pkg::*;

   localparam int unsigned DEPTH = TABLE_DEPTH_DEFAULT;
   // Mode 3 has no operation behind it, so the block must ignore it.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR = {REG_SEED_VALUE, 2'b00};

   // Generator constants used by the predictor.
   localparam logic [63:0] GEN_MULT       = 64'd18705;
   localparam logic [31:0] GEN_BASE       = 32'hffff_fffe;
   localparam logic [31:0] GEN_GOLDEN     = 32'h9e37_79b9;
   localparam logic [18:0] GEN_CARRY_INIT = 19'd362436;
   localparam logic [11:0] GEN_POS_INIT   = 12'd4095;

   // A seed word keeps the block busy for a fill and a warm-up pass over the table.
   localparam int SETTLE_CYCLES  = 2 * DEPTH + 64;
   localparam int WATCHDOG_LIMIT = 50000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = MODE_DRAW;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predicted generator state.
   logic [31:0] lag_model [DEPTH];
   bit          entry_valid [DEPTH];
   logic [18:0] carry_model;
   logic [11:0] pos_model;
   logic [31:0] seed_model;

   logic [31:0] expected_words [$];
   int          error_count = 0;
   bit          gaps_on     = 1'b0;
   bit          stalls_on   = 1'b0;

   cmwc_random_generator_unit u_dut (.*);

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Advance the position and produce one random word.
   function automatic logic [31:0] draw_word();
      logic [63:0] t;
      pos_model = pos_model + 12'd1;
      t = GEN_MULT * {32'd0, lag_model[pos_model]} + {45'd0, carry_model};
      carry_model = t[50:32];
      lag_model[pos_model] = GEN_BASE - t[31:0];
      return lag_model[pos_model];
   endfunction

   // Refill the table from the seed register, then warm up silently.
   function automatic void reseed_table();
      int k;
      lag_model[0] = seed_model;
      lag_model[1] = seed_model + GEN_GOLDEN;
      lag_model[2] = seed_model + GEN_GOLDEN + GEN_GOLDEN;
      for (k = 3; k < DEPTH; k++)
         lag_model[k] = lag_model[k-3] ^ lag_model[k-2] ^ GEN_GOLDEN ^ 32'(k);
      for (k = 0; k < DEPTH; k++)
         entry_valid[k] = 1'b1;
      for (k = 0; k < DEPTH; k++)
         void'(draw_word());
   endfunction

   // Update the predicted state for one accepted request word.
   function automatic void predict_word(logic [1:0] mode, logic [11:0] index,
                                        logic [31:0] value);
      case (mode)
         MODE_DRAW: expected_words.push_back(draw_word());
         MODE_SEED: reseed_table();
         MODE_LOAD: begin
            lag_model[index]   = value;
            entry_valid[index] = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // Offer one request word, after a random gap if gaps are on, and wait for it to be taken.
   task automatic send_word(input logic [1:0] mode, input logic [11:0] index,
                            input logic [31:0] value);
      int gap;
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0000, value, index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(mode, index, value);
   endtask

   // Stop sending and wait until every predicted word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   // Drain, then let any seed still running in the block finish.
   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the seed register: setup phase, then access phase.
   task automatic write_seed(input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SEED_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      seed_model = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Random traffic after a fresh seed: mostly draws, loads near the position, unused modes, reseeds.
   task automatic run_random_phase(input logic [31:0] seed_word, input int count,
                                   input bit idle, input int drain_every);
      int          sent;
      int          since_drain;
      int          pick;
      logic [11:0] index;
      logic [11:0] ahead;
      settle();
      write_seed(seed_word);
      gaps_on   = idle;
      stalls_on = idle;
      send_word(MODE_SEED, 12'($urandom), $urandom);
      sent        = 0;
      since_drain = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            ahead = pos_model + 12'd1;
            if (entry_valid[ahead])
               send_word(MODE_DRAW, 12'($urandom), $urandom);
            else
               send_word(MODE_LOAD, ahead, $urandom);
            sent++;
            since_drain++;
         end else if (pick < 95) begin
            if ($urandom_range(0, 1) == 1)
               index = pos_model + 12'($urandom_range(1, 8));
            else
               index = 12'($urandom);
            send_word(MODE_LOAD, index, $urandom);
            sent++;
            since_drain++;
         end else if (pick < 99) begin
            send_word(MODE_UNUSED, 12'($urandom), $urandom);
         end else begin
            send_word(MODE_SEED, 12'($urandom), $urandom);
            sent++;
            since_drain++;
         end
         if (drain_every > 0 && since_drain >= drain_every) begin
            drain_results();
            since_drain = 0;
         end
      end
   endtask

   // Hand-loaded entries before any seeding; the first draws use the carry from reset.
   task automatic test_loaded_draws();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      send_word(MODE_LOAD, 12'd0, 32'hffff_ffff);
      send_word(MODE_LOAD, 12'd1, 32'h0000_0000);
      send_word(MODE_LOAD, 12'd2, 32'h8000_0001);
      send_word(MODE_LOAD, 12'd3, 32'h5555_aaaa);
      send_word(MODE_LOAD, 12'd4095, 32'hffff_ffff);
      // Draw words carry junk in their ignored fields.
      send_word(MODE_DRAW, 12'hfff, 32'hffff_ffff);
      send_word(MODE_DRAW, 12'h000, 32'h0000_0000);
      // The unused mode must leave entry 3 untouched.
      send_word(MODE_UNUSED, 12'd3, 32'hffff_ffff);
      send_word(MODE_DRAW, 12'h0aa, 32'h1234_5678);
      send_word(MODE_DRAW, 12'h555, 32'h8765_4321);
      // Load straight into the entry the next draw reads.
      send_word(MODE_LOAD, 12'd4, 32'hdead_beef);
      send_word(MODE_DRAW, 12'd0, 32'd0);
   endtask

   // Seeding with the extreme seed values; carry and position carry over.
   task automatic test_seed_extremes();
      settle();
      write_seed(32'h0000_0000);
      send_word(MODE_SEED, 12'hfff, 32'hffff_ffff);
      send_word(MODE_DRAW, 12'd0, 32'd0);
      send_word(MODE_DRAW, 12'd0, 32'd0);
      send_word(MODE_LOAD, pos_model + 12'd1, 32'h0000_0000);
      send_word(MODE_DRAW, 12'd0, 32'd0);
      settle();
      write_seed(32'hffff_ffff);
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      send_word(MODE_SEED, 12'd0, 32'd0);
      send_word(MODE_DRAW, 12'd0, 32'd0);
      send_word(MODE_DRAW, 12'd0, 32'd0);
      send_word(MODE_DRAW, 12'd0, 32'd0);
   endtask

   // Long random runs, the first with no idling on either side.
   task automatic test_random_traffic();
      run_random_phase($urandom, 220, 1'b0, 0);
      run_random_phase($urandom, 220, 1'b1, 0);
      run_random_phase($urandom, 220, 1'b1, 0);
   endtask

   // Random traffic where the sender stops now and then until all results are back.
   task automatic test_drain_pauses();
      run_random_phase($urandom, 220, 1'b1, 30);
   endtask

   // Result side: random stall before each word when stalls are on, then hold ready until one is taken.
   initial begin : result_sink
      int stall;
      forever begin
         stall = stalls_on ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) @(posedge clock);
      end
   end

   // Compare each accepted result word with the oldest prediction.
   always @(posedge clock) begin : result_check
      logic [31:0] wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            error_count++;
            $display("%0t: result word with none expected, expected none, actual %h",
                     $time, rsp_tdata);
         end else begin
            wanted = expected_words.pop_front();
            if (rsp_tdata !== wanted) begin
               error_count++;
               $display("%0t: random_word mismatch, expected %h, actual %h",
                        $time, wanted, rsp_tdata);
            end
         end
      end
   end

   // End the run if nothing moves on any port for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_psel && csr_penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("status: fail");
      $finish;
   end

   // Reset, run every test in turn, then report.
   initial begin
      carry_model = GEN_CARRY_INIT;
      pos_model   = GEN_POS_INIT;
      seed_model  = '0;
      foreach (entry_valid[i])
         entry_valid[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_loaded_draws();
      test_seed_extremes();
      test_random_traffic();
      test_drain_pauses();
      settle();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
